FILE: rtl/elrgb_pkg.sv
// ----------------------------------------------------------------------------
// Elevation colormap package
// Shared constants, command codes and controller/datapath interface types.
// ----------------------------------------------------------------------------
package elrgb_pkg;

   localparam int ELEV_BITS_DEF = 16;
   localparam int CMD_BITS      = 2;
   localparam int COLOR_BITS    = 8;
   localparam int QUO_BITS      = COLOR_BITS + 1;
   localparam int STEP_BITS     = $clog2(QUO_BITS);

   localparam logic [COLOR_BITS-1:0] COLOR_MAX = {COLOR_BITS{1'b1}};

   typedef enum logic [CMD_BITS-1:0] {
      CMD_CLEAR = 2'd0,
      CMD_ACCUM = 2'd1,
      CMD_MAP   = 2'd2
   } cmd_type;

   typedef struct packed {
      logic clear_stats;
      logic accum;
      logic capture;
      logic prep;
      logic div_step;
      logic load_out;
   } dp_cmd_type;

   typedef struct packed {
      logic div_last;
   } dp_status_type;

endpackage

FILE: rtl/elevation_to_rgb_colormap.sv
// ----------------------------------------------------------------------------
// Elevation to RGB colormap
// Two-pass blue-green-red heatmap over a tile of signed elevation samples.
// ----------------------------------------------------------------------------
//   Channel  Direction  Contents
//   req_     in         tuser: cmd; tdata: elevation
//   rsp_     out        tdata: red, green, blue
//   csr_     in         write of nodata_value
//
// Clear and accumulate words update the statistics as they are accepted. A map
// word runs through capture, offset and range arithmetic, nine restoring divider
// steps for the saturating quotient, and a load of the result register.
// Reset is synchronous and restores empty statistics and the default no-data
// code. The result register lets the next word be accepted while a result waits;
// a map word stalls only in its load step until that register is free.
// ----------------------------------------------------------------------------
module elevation_to_rgb_colormap #(
   parameter int ELEV_BITS = elrgb_pkg::ELEV_BITS_DEF
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_tvalid,
   output logic                                  req_tready,
   input  logic [((ELEV_BITS+7)/8)*8-1:0]        req_tdata,  // elevation
   input  logic [elrgb_pkg::CMD_BITS-1:0]        req_tuser,  // cmd
   output logic                                  rsp_tvalid,
   input  logic                                  rsp_tready,
   output logic [3*elrgb_pkg::COLOR_BITS-1:0]    rsp_tdata,  // red, green, blue
   input  logic                                  csr_wen,
   input  logic [ELEV_BITS-1:0]                  csr_wdata
);

   localparam int CB = elrgb_pkg::COLOR_BITS;

   elrgb_pkg::dp_cmd_type    dp_cmd;
   elrgb_pkg::dp_status_type dp_status;
   logic [CB-1:0]            red, green, blue;

   elrgb_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_cmd    (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .dp_cmd     (dp_cmd),
      .dp_status  (dp_status)
   );

   elrgb_datapath #(
      .ELEV_BITS (ELEV_BITS)
   ) u_datapath (
      .clock         (clock),
      .reset         (reset),
      .req_elevation (req_tdata[ELEV_BITS-1:0]),
      .csr_wen       (csr_wen),
      .csr_wdata     (csr_wdata),
      .dp_cmd        (dp_cmd),
      .dp_status     (dp_status),
      .rsp_red       (red),
      .rsp_green     (green),
      .rsp_blue      (blue)
   );

   assign rsp_tdata = {blue, green, red};

endmodule

FILE: rtl/elrgb_ctrl.sv
// ----------------------------------------------------------------------------
// Elevation colormap controller
// Decodes commands, sequences the divider and owns the result valid flag.
// ----------------------------------------------------------------------------
module elrgb_ctrl (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_tvalid,
   output logic                          req_tready,
   input  logic [elrgb_pkg::CMD_BITS-1:0] req_cmd,
   output logic                          rsp_tvalid,
   input  logic                          rsp_tready,
   output elrgb_pkg::dp_cmd_type         dp_cmd,
   input  elrgb_pkg::dp_status_type      dp_status
);

   typedef enum logic [3:0] {
      ST_IDLE = 4'b0001,
      ST_PREP = 4'b0010,
      ST_DIV  = 4'b0100,
      ST_DONE = 4'b1000
   } state_type;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;
   logic      accept;

   assign req_tready = (state_ff == ST_IDLE);
   assign accept     = req_tvalid && req_tready;
   assign rsp_tvalid = rsp_valid_ff;

   always_comb begin
      state_in = state_ff;
      dp_cmd   = '0;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               unique case (elrgb_pkg::cmd_type'(req_cmd))
                  elrgb_pkg::CMD_CLEAR: dp_cmd.clear_stats = 1'b1;
                  elrgb_pkg::CMD_ACCUM: dp_cmd.accum = 1'b1;
                  elrgb_pkg::CMD_MAP: begin
                     dp_cmd.capture = 1'b1;
                     state_in       = ST_PREP;
                  end
                  default: ;
               endcase
            end
         end
         ST_PREP: begin
            dp_cmd.prep = 1'b1;
            state_in    = ST_DIV;
         end
         ST_DIV: begin
            dp_cmd.div_step = 1'b1;
            if (dp_status.div_last) begin
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            if (!rsp_valid_ff || rsp_tready) begin
               dp_cmd.load_out = 1'b1;
               state_in        = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (dp_cmd.load_out) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

FILE: rtl/elrgb_datapath.sv
// ----------------------------------------------------------------------------
// Elevation colormap datapath
// Tile statistics, offset and range arithmetic, restoring divider and
// color output registers.
// ----------------------------------------------------------------------------
module elrgb_datapath #(
   parameter int ELEV_BITS = elrgb_pkg::ELEV_BITS_DEF
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic [ELEV_BITS-1:0]               req_elevation,
   input  logic                               csr_wen,
   input  logic [ELEV_BITS-1:0]               csr_wdata,
   input  elrgb_pkg::dp_cmd_type              dp_cmd,
   output elrgb_pkg::dp_status_type           dp_status,
   output logic [elrgb_pkg::COLOR_BITS-1:0]   rsp_red,
   output logic [elrgb_pkg::COLOR_BITS-1:0]   rsp_green,
   output logic [elrgb_pkg::COLOR_BITS-1:0]   rsp_blue
);

   localparam int CB       = elrgb_pkg::COLOR_BITS;
   localparam int NUM_BITS = ELEV_BITS + 1 + CB;

   localparam logic [ELEV_BITS-1:0] ELEV_MAX = {1'b0, {(ELEV_BITS-1){1'b1}}};
   localparam logic [ELEV_BITS-1:0] ELEV_MIN = {1'b1, {(ELEV_BITS-1){1'b0}}};

   logic signed [ELEV_BITS-1:0] nodata_ff, highest_ff, lowest_ff, elev_ff;
   logic signed [ELEV_BITS-1:0] elev_in;
   logic [NUM_BITS-1:0]         num_ff, num_in, div_ff, div_in;
   logic [elrgb_pkg::QUO_BITS-1:0]  quo_ff, quo_in;
   logic [elrgb_pkg::STEP_BITS-1:0] step_ff, step_in;
   logic                        red_sel_ff, red_sel_in, flat_ff, flat_in;
   logic [CB-1:0]               red_ff, green_ff, blue_ff;
   logic [CB-1:0]               red_in, green_in, blue_in;

   logic signed [ELEV_BITS:0]   offset, range_s;
   logic [ELEV_BITS-1:0]        offset_c, range_u;
   logic [ELEV_BITS:0]          e2, diff;
   logic [CB-1:0]               quo_sat;

   assign elev_in = $signed(req_elevation);

   // Offset from the minimum, clamped at zero, and the tile range.
   always_comb begin
      offset   = {elev_ff[ELEV_BITS-1], elev_ff} - {lowest_ff[ELEV_BITS-1], lowest_ff};
      range_s  = {highest_ff[ELEV_BITS-1], highest_ff}
               - {lowest_ff[ELEV_BITS-1], lowest_ff};
      offset_c = offset[ELEV_BITS] ? '0 : offset[ELEV_BITS-1:0];
      range_u  = range_s[ELEV_BITS-1:0];
      e2       = {offset_c, 1'b0};
      red_sel_in = (e2 > {1'b0, range_u});
      flat_in    = range_s[ELEV_BITS] || (range_s == '0);
      diff       = red_sel_in ? (e2 - {1'b0, range_u}) : ({1'b0, range_u} - e2);
   end

   // Restoring division, one quotient bit per step, most significant first.
   always_comb begin
      num_in  = num_ff;
      div_in  = div_ff;
      quo_in  = quo_ff;
      step_in = step_ff;
      if (dp_cmd.prep) begin
         num_in  = {diff, {CB{1'b0}}} - {{CB{1'b0}}, diff};
         div_in  = {1'b0, range_u, {CB{1'b0}}};
         quo_in  = '0;
         step_in = '0;
      end else if (dp_cmd.div_step) begin
         if (num_ff >= div_ff) begin
            num_in = num_ff - div_ff;
            quo_in = {quo_ff[elrgb_pkg::QUO_BITS-2:0], 1'b1};
         end else begin
            quo_in = {quo_ff[elrgb_pkg::QUO_BITS-2:0], 1'b0};
         end
         div_in  = {1'b0, div_ff[NUM_BITS-1:1]};
         step_in = step_ff + 1'b1;
      end
   end

   assign dp_status.div_last =
      (step_ff == elrgb_pkg::STEP_BITS'(elrgb_pkg::QUO_BITS - 1));

   always_comb begin
      quo_sat  = quo_ff[elrgb_pkg::QUO_BITS-1] ? elrgb_pkg::COLOR_MAX : quo_ff[CB-1:0];
      red_in   = red_ff;
      green_in = green_ff;
      blue_in  = blue_ff;
      if (dp_cmd.load_out) begin
         if (flat_ff) begin
            red_in   = '0;
            green_in = '0;
            blue_in  = elrgb_pkg::COLOR_MAX;
         end else if (red_sel_ff) begin
            red_in   = quo_sat;
            green_in = elrgb_pkg::COLOR_MAX - quo_sat;
            blue_in  = '0;
         end else begin
            red_in   = '0;
            green_in = elrgb_pkg::COLOR_MAX - quo_sat;
            blue_in  = quo_sat;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         nodata_ff  <= ELEV_MIN;
         highest_ff <= '0;
         lowest_ff  <= ELEV_MAX;
      end else begin
         if (csr_wen) begin
            nodata_ff <= csr_wdata;
         end
         if (dp_cmd.clear_stats) begin
            highest_ff <= '0;
            lowest_ff  <= ELEV_MAX;
         end else if (dp_cmd.accum) begin
            if (elev_in > highest_ff) begin
               highest_ff <= elev_in;
            end
            if ((elev_in != nodata_ff) && (elev_in < lowest_ff)) begin
               lowest_ff <= elev_in;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (dp_cmd.capture) begin
         elev_ff <= elev_in;
      end
      if (dp_cmd.prep) begin
         red_sel_ff <= red_sel_in;
         flat_ff    <= flat_in;
      end
      num_ff   <= num_in;
      div_ff   <= div_in;
      quo_ff   <= quo_in;
      step_ff  <= step_in;
      red_ff   <= red_in;
      green_ff <= green_in;
      blue_ff  <= blue_in;
   end

   assign rsp_red   = red_ff;
   assign rsp_green = green_ff;
   assign rsp_blue  = blue_ff;

endmodule

FILE: dv/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Elevation to RGB colormap testbench
// Streams tiles of clear, accumulate and map words into the colormap block,
// predicts each pixel from its own copy of the tile statistics, and checks
// every result word in order while both sides idle and stall at random when bursty.
// ----------------------------------------------------------------------------
module tb;

   localparam int ELEV_W       = elrgb_pkg::ELEV_BITS_DEF;
   localparam int CMD_W        = elrgb_pkg::CMD_BITS;
   localparam int CB           = elrgb_pkg::COLOR_BITS;
   localparam int TOTAL_WORDS  = 1150;
   localparam int CYCLE_LIMIT  = 400000;
   localparam int DRAIN_CYCLES = 16;
   localparam int HOLD_CYCLES  = 300;

   localparam logic [CMD_W-1:0] CMD_RESERVED = 2'd3;

   typedef struct packed {
      logic [CMD_W-1:0]         cmd;
      logic signed [ELEV_W-1:0] elev;
   } tile_word_type;

   typedef struct packed {
      logic [CB-1:0] red;
      logic [CB-1:0] green;
      logic [CB-1:0] blue;
   } pixel_type;

   logic                             clock = 1'b0;
   logic                             reset = 1'b1;
   logic                             req_tvalid = 1'b0;
   logic                             req_tready;
   logic [((ELEV_W+7)/8)*8-1:0]      req_tdata = '0;   // elevation
   logic [CMD_W-1:0]                 req_tuser = '0;   // cmd
   logic                             rsp_tvalid;
   logic                             rsp_tready = 1'b0;
   logic [3*CB-1:0]                  rsp_tdata;        // red, green, blue
   logic                             csr_wen = 1'b0;
   logic [ELEV_W-1:0]                csr_wdata = '0;

   tile_word_type tile_words[$];
   pixel_type     expected_pixels[$];
   tile_word_type next_word;

   logic signed [ELEV_W-1:0] highest_elev;
   logic signed [ELEV_W-1:0] lowest_elev;
   logic signed [ELEV_W-1:0] nodata_code;

   logic req_fire = 1'b0;
   logic bursty = 1'b1;
   logic calm = 1'b0;
   logic hold_req = 1'b0;
   logic hold_ack = 1'b0;
   int   hold_left = 0;
   int   send_gap = 0;
   int   recv_gap = 0;
   int   words_queued = 0;
   int   errors = 0;
   int   cycles = 0;

   elevation_to_rgb_colormap #(.ELEV_BITS(ELEV_W)) DUT (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_wen    (csr_wen),
      .csr_wdata  (csr_wdata)
   );

   initial begin
      forever #4 clock = ~clock;
   end

   task automatic report(input string msg);
      $display("ERROR at %0t: %s", $time, msg);
      errors++;
   endtask

   task automatic clear_stats();
      highest_elev = '0;
      lowest_elev  = {1'b0, {(ELEV_W-1){1'b1}}};
   endtask

   // Updates the tile statistics for one word and, for a map word, computes its pixel.
   task automatic color_word(input logic [CMD_W-1:0] cmd,
                             input logic signed [ELEV_W-1:0] elev);
      int        offset;
      int        span;
      int        twice;
      int        r;
      int        g;
      int        b;
      pixel_type px;
      case (cmd)
         elrgb_pkg::CMD_CLEAR: begin
            clear_stats();
         end
         elrgb_pkg::CMD_ACCUM: begin
            if (elev > highest_elev) highest_elev = elev;
            if (elev != nodata_code && elev < lowest_elev) lowest_elev = elev;
         end
         elrgb_pkg::CMD_MAP: begin
            offset = int'(elev) - int'(lowest_elev);
            span   = int'(highest_elev) - int'(lowest_elev);
            if (offset < 0) offset = 0;
            twice = 2 * offset;
            r = 0;
            b = 0;
            if (span <= 0) begin
               b = 255;
            end else if (twice <= span) begin
               b = (255 * (span - twice)) / span;
            end else begin
               r = (255 * (twice - span)) / span;
               if (r > 255) r = 255;
            end
            g = 255 - r - b;
            if (g < 0) g = 0;
            px.red   = r[CB-1:0];
            px.green = g[CB-1:0];
            px.blue  = b[CB-1:0];
            expected_pixels.push_back(px);
         end
         default: ;
      endcase
   endtask

   always @(posedge clock) begin
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
         $display("Test completed with failures");
         $finish;
      end
   end

   always @(posedge clock) begin
      req_fire = !reset && req_tvalid && req_tready;
      if (req_fire) color_word(req_tuser, req_tdata[ELEV_W-1:0]);
   end

   always @(negedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
      end else if (!req_tvalid || req_fire) begin
         if (send_gap > 0) begin
            send_gap--;
            req_tvalid <= 1'b0;
         end else if (bursty && !calm && $urandom_range(0, 9) == 0) begin
            send_gap = $urandom_range(0, 4);
            req_tvalid <= 1'b0;
         end else if (tile_words.size() > 0) begin
            next_word = tile_words.pop_front();
            req_tvalid <= 1'b1;
            req_tuser  <= next_word.cmd;
            req_tdata  <= next_word.elev;
         end else begin
            req_tvalid <= 1'b0;
         end
      end
   end

   always @(posedge clock) begin
      if (hold_req != hold_ack) begin
         hold_ack  <= hold_req;
         hold_left <= HOLD_CYCLES;
      end else if (hold_left > 0) begin
         hold_left <= hold_left - 1;
      end
   end

   always @(negedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else if (recv_gap > 0) begin
         recv_gap--;
         rsp_tready <= 1'b0;
      end else if (bursty && !calm && $urandom_range(0, 7) == 0) begin
         recv_gap = $urandom_range(0, 4);
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= (hold_left == 0);
      end
   end

   always @(posedge clock) begin
      pixel_type want;
      pixel_type got;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got.red   = rsp_tdata[CB-1:0];
         got.green = rsp_tdata[2*CB-1:CB];
         got.blue  = rsp_tdata[3*CB-1:2*CB];
         if (expected_pixels.size() == 0) begin
            report($sformatf("unexpected pixel r=%0d g=%0d b=%0d",
                             got.red, got.green, got.blue));
         end else begin
            want = expected_pixels.pop_front();
            if (got.red != want.red)
               report($sformatf("red got %0d, expected %0d", got.red, want.red));
            if (got.green != want.green)
               report($sformatf("green got %0d, expected %0d", got.green, want.green));
            if (got.blue != want.blue)
               report($sformatf("blue got %0d, expected %0d", got.blue, want.blue));
         end
      end
   end

   function automatic logic signed [ELEV_W-1:0] clip_elev(input int v);
      if (v > 32767) return 16'sd32767;
      if (v < -32768) return -16'sd32768;
      return v[ELEV_W-1:0];
   endfunction

   task automatic add_word(input logic [CMD_W-1:0] cmd, input int elev);
      tile_word_type w;
      w.cmd  = cmd;
      w.elev = clip_elev(elev);
      tile_words.push_back(w);
      words_queued++;
   endtask

   task automatic wait_drained();
      while (tile_words.size() > 0 || req_tvalid || expected_pixels.size() > 0)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic write_nodata(input logic signed [ELEV_W-1:0] v);
      @(negedge clock);
      csr_wen   = 1'b1;
      csr_wdata = v;
      @(negedge clock);
      csr_wen   = 1'b0;
      nodata_code = v;
   endtask

   // A tile is an optional clear, a pass of samples and a pass of map words around the same span.
   task automatic queue_tile();
      int samples;
      int maps;
      int spread;
      int base;
      int v;
      samples = $urandom_range(1, 12);
      maps    = $urandom_range(1, 12);
      case ($urandom_range(0, 3))
         0: spread = $urandom_range(0, 3);
         1: spread = $urandom_range(4, 300);
         2: spread = $urandom_range(301, 20000);
         default: spread = 65535;
      endcase
      if (spread == 65535) base = -32768;
      else if ($urandom_range(0, 2) == 0) base = nodata_code;
      else base = int'($urandom_range(0, 65535 - spread)) - 32768;
      if ($urandom_range(0, 7) != 0) add_word(elrgb_pkg::CMD_CLEAR, $urandom);
      repeat (samples) begin
         v = base + int'($urandom_range(0, spread));
         if ($urandom_range(0, 7) == 0) v = nodata_code;
         add_word(elrgb_pkg::CMD_ACCUM, v);
      end
      repeat (maps) begin
         v = base - spread / 4 + int'($urandom_range(0, spread + spread / 2));
         if ($urandom_range(0, 9) == 0) v = $signed(16'($urandom));
         if ($urandom_range(0, 11) == 0) v = nodata_code;
         add_word(elrgb_pkg::CMD_MAP, v);
      end
   endtask

   task automatic queue_noise();
      repeat ($urandom_range(1, 8))
         add_word(CMD_W'($urandom), $signed(16'($urandom)));
   endtask

   initial begin
      int phase;
      int target;
      logic signed [ELEV_W-1:0] code;
      clear_stats();
      nodata_code = -16'sd32768;
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // Empty statistics, flat and full ranges, no-data samples, saturation.
      add_word(elrgb_pkg::CMD_MAP, 0);
      add_word(elrgb_pkg::CMD_CLEAR, -1);
      add_word(elrgb_pkg::CMD_ACCUM, 32767);
      add_word(elrgb_pkg::CMD_ACCUM, -32768);
      add_word(elrgb_pkg::CMD_MAP, 5);
      add_word(elrgb_pkg::CMD_ACCUM, -32767);
      add_word(elrgb_pkg::CMD_MAP, -32768);
      add_word(elrgb_pkg::CMD_MAP, 32767);
      add_word(elrgb_pkg::CMD_MAP, 0);
      add_word(elrgb_pkg::CMD_MAP, -1);
      add_word(CMD_RESERVED, -1);
      add_word(elrgb_pkg::CMD_MAP, 1);
      add_word(elrgb_pkg::CMD_CLEAR, 0);
      add_word(elrgb_pkg::CMD_ACCUM, -5);
      add_word(elrgb_pkg::CMD_ACCUM, -100);
      add_word(elrgb_pkg::CMD_MAP, 50);
      add_word(elrgb_pkg::CMD_MAP, -50);
      add_word(elrgb_pkg::CMD_MAP, -100);
      add_word(elrgb_pkg::CMD_MAP, -75);
      add_word(elrgb_pkg::CMD_MAP, 0);
      add_word(CMD_RESERVED, 0);
      add_word(elrgb_pkg::CMD_MAP, -25);
      wait_drained();

      target = words_queued + TOTAL_WORDS;
      phase = 0;
      while (words_queued < target) begin
         case (phase % 6)
            0: code = 16'sd32767;
            1: code = -16'sd32768;
            2: code = 16'sd0;
            3: code = -16'sd1;
            default: code = $signed(16'($urandom));
         endcase
         write_nodata(code);
         bursty = ($urandom_range(0, 3) != 0) || phase == 2;
         calm   = (words_queued > target - 150);
         while (words_queued < target && tile_words.size() < 120) begin
            if ($urandom_range(0, 9) < 8) queue_tile();
            else queue_noise();
         end
         if (phase == 2) hold_req = ~hold_req;
         wait_drained();
         phase++;
      end

      if (errors == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end

endmodule
